// ===== hdl/smvmac_pkg.sv =====
// ----------------------------------------------------------------------------
// smvmac_pkg: shared types and constants
// Sizes, command codes and the beat record that flows down the row chain.
// ----------------------------------------------------------------------------
package smvmac_pkg;

   // array geometry
   localparam int ARRAY_SIZE = 8;
   localparam int BYTE_W     = 8;
   localparam int LANE_W     = 64;
   localparam int DATA_W     = ARRAY_SIZE * BYTE_W;
   localparam int PROD_W     = 2 * BYTE_W;
   localparam int SUM_W      = 19;
   localparam int COL_W      = 3;
   localparam int IDX_W      = (ARRAY_SIZE > 1) ? $clog2(ARRAY_SIZE) : 1;

   // signed 16-bit range used for the overflow flag
   localparam logic signed [SUM_W-1:0] INT16_MIN = -19'sd32768;
   localparam logic signed [SUM_W-1:0] INT16_MAX = 19'sd32767;

   // command codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MULT = 1'b1
   } smvmac_cmd_type;

   // one beat in the chain: a weight row being pushed down, or a vector
   // collecting column sums
   typedef struct packed {
      logic                                valid;
      smvmac_cmd_type                      cmd;
      logic [DATA_W-1:0]                   data;
      logic [ARRAY_SIZE-1:0][SUM_W-1:0]    sum;
      logic [ARRAY_SIZE-1:0]               over;
   } smvmac_beat_type;

endpackage

// ===== hdl/smvmac_cell.sv =====
// ----------------------------------------------------------------------------
// smvmac_cell: one weight row of the array
// Holds one row of weights. A load beat swaps its row in and carries the old
// row on to the next cell; a vector beat adds lane * weight to every column.
// ----------------------------------------------------------------------------
module smvmac_cell
   import smvmac_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  smvmac_beat_type beat_i,
   output smvmac_beat_type beat_o
);

   logic [ARRAY_SIZE-1:0][BYTE_W-1:0] weight_ff;
   smvmac_beat_type                   beat_ff;
   smvmac_beat_type                   beat_in;
   logic signed [BYTE_W-1:0]          lane;
   logic signed [PROD_W-1:0]          prod [ARRAY_SIZE];
   logic signed [SUM_W-1:0]           acc  [ARRAY_SIZE];

   // this row's lane is always the low byte; the vector shifts down a byte per cell
   assign lane = $signed(beat_i.data[BYTE_W-1:0]);

   // per-column products and running sums
   always_comb begin
      for (int c = 0; c < ARRAY_SIZE; c++) begin
         prod[c] = lane * $signed(weight_ff[c]);
         acc[c]  = $signed(beat_i.sum[c])
                 + $signed({{(SUM_W-PROD_W){prod[c][PROD_W-1]}}, prod[c]});
      end
   end

   // next beat
   always_comb begin
      beat_in = beat_i;
      unique case (beat_i.cmd)
         CMD_LOAD: begin
            beat_in.data = weight_ff;
         end
         CMD_MULT: begin
            beat_in.data = beat_i.data >> BYTE_W;
            for (int c = 0; c < ARRAY_SIZE; c++) begin
               beat_in.sum[c]  = acc[c];
               beat_in.over[c] = beat_i.over[c] || (acc[c] < INT16_MIN)
                                 || (acc[c] > INT16_MAX);
            end
         end
      endcase
   end

   // weight row: replaced when a load beat passes
   always_ff @(posedge clock) begin
      if (advance && beat_i.valid && (beat_i.cmd == CMD_LOAD)) begin
         weight_ff <= beat_i.data;
      end
   end

   // beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

// ===== hdl/smvmac_drain.sv =====
// ----------------------------------------------------------------------------
// smvmac_drain: column serializer
// Takes finished vectors off the end of the chain and sends one column sum
// per transfer. Holds the chain while a vector waits for the port.
// ----------------------------------------------------------------------------
module smvmac_drain
   import smvmac_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  smvmac_beat_type         beat_i,
   output logic                    advance,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COL_W-1:0]        rsp_column_index,
   output logic signed [SUM_W-1:0] rsp_column_sum,
   output logic                    rsp_exceeds_int16,
   output logic                    rsp_last_column
);

   logic                             busy_ff;
   logic [COL_W-1:0]                 count_ff;
   logic [ARRAY_SIZE-1:0][SUM_W-1:0] sum_ff;
   logic [ARRAY_SIZE-1:0]            over_ff;
   logic                             last_col;
   logic                             done;
   logic                             free;
   logic                             vec_arrives;
   logic                             take;

   assign last_col    = (count_ff == COL_W'(ARRAY_SIZE - 1));
   assign done        = busy_ff && rsp_ready && last_col;
   assign free        = !busy_ff || done;
   assign vec_arrives = beat_i.valid && (beat_i.cmd == CMD_MULT);
   assign take        = vec_arrives && free;

   // chain moves unless a finished vector has nowhere to go
   assign advance = !vec_arrives || free;

   // column counter and hold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (take) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (last_col) begin
            busy_ff <= 1'b0;
         end else begin
            count_ff <= count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sum_ff  <= beat_i.sum;
         over_ff <= beat_i.over;
      end
   end

   // result port
   assign rsp_valid         = busy_ff;
   assign rsp_column_index  = count_ff;
   assign rsp_column_sum    = $signed(sum_ff[count_ff[IDX_W-1:0]]);
   assign rsp_exceeds_int16 = over_ff[count_ff[IDX_W-1:0]];
   assign rsp_last_column   = last_col;

   // a stall only ever comes from a vector waiting on a busy serializer
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (busy_ff && vec_arrives && !done))
      else $error("chain stalled without a waiting vector");

   // a taken vector starts at column zero
   a_take_start: assert property (@(posedge clock) disable iff (reset)
      take |=> (busy_ff && (count_ff == '0)))
      else $error("serializer did not start at column zero");

   // the final column transfer empties the serializer unless a vector follows
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (done && !take) |=> !busy_ff)
      else $error("serializer stayed busy after last column");

   // column counter stays inside the array
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff <= COL_W'(ARRAY_SIZE - 1)))
      else $error("column counter out of range");

endmodule

// ===== hdl/systolic_matrix_vector_mac.sv =====
// ----------------------------------------------------------------------------
// systolic_matrix_vector_mac: weight-stationary matrix-vector MAC
// A chain of row cells holding the weight array, followed by a serializer.
//
// Usage:
//  - req channel: req_command selects a weight-row load or a vector multiply;
//    req_lane_values carries eight signed bytes (row weights or lane values).
//  - A load pushes its row into the top cell; each cell hands its old row to
//    the cell below, so after ARRAY_SIZE loads the first row sits at the bottom.
//  - A multiply walks down the chain, one cell per cycle while the chain is not
//    held, collecting all column sums, then leaves on rsp as ARRAY_SIZE
//    transfers, column 0 first, the last one marked by rsp_last_column.
//  - The first column is valid once the serializer takes the multiply from
//    the chain; further columns follow one per cycle while rsp_ready is high.
//  - Flow: loads are taken one per cycle while the chain is not held. A
//    multiply holds the single result port until its last column is sent;
//    the chain still accepts a beat every cycle until a vector waits at its end.
//  - Stall: when another vector reaches the chain end before the last column
//    is sent, the whole chain holds and req_ready drops until the port frees up.
//  - Reset clears the chain and serializer; weights are undefined until
//    ARRAY_SIZE rows are loaded.
// ----------------------------------------------------------------------------
module systolic_matrix_vector_mac
   import smvmac_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [LANE_W-1:0]       req_lane_values,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COL_W-1:0]        rsp_column_index,
   output logic signed [SUM_W-1:0] rsp_column_sum,
   output logic                    rsp_exceeds_int16,
   output logic                    rsp_last_column
);

   smvmac_beat_type beat [ARRAY_SIZE+1];
   logic            advance;

   // beat entering the top cell
   assign beat[0] = '{valid: req_valid,
                      cmd:   smvmac_cmd_type'(req_command),
                      data:  req_lane_values[DATA_W-1:0],
                      sum:   '0,
                      over:  '0};

   assign req_ready = advance;

   // row cells
   for (genvar r = 0; r < ARRAY_SIZE; r++) begin : g_row
      smvmac_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .beat_i  (beat[r]),
         .beat_o  (beat[r+1])
      );
   end

   // column serializer
   smvmac_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .beat_i            (beat[ARRAY_SIZE]),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_index  (rsp_column_index),
      .rsp_column_sum    (rsp_column_sum),
      .rsp_exceeds_int16 (rsp_exceeds_int16),
      .rsp_last_column   (rsp_last_column)
   );

endmodule
